>>> src/ws3_pkg.sv
// ----------------------------------------------------------------------------
// ws3_pkg
// Shared constants, item control struct and fixed-weight tap arithmetic for
// the weighted 3x3 RGB stencil.
// ----------------------------------------------------------------------------
package ws3_pkg;

  localparam int MAX_SIZE_DEF = 1024;
  localparam int CH_W         = 16;
  localparam int PIX_W        = 3 * CH_W;
  localparam int CFG_W        = 11;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic emit;
    logic last;
    logic row1;
    logic row2;
    logic col1;
    logic col2;
  } ws3_ctl_t;

  // floor(v / 5), exact for v below 2**18
  function automatic logic [CH_W-1:0] div5(input logic [17:0] v);
    logic [35:0] p;
    p = 36'(v) * 36'd52429;
    return p[33:18];
  endfunction

  function automatic logic [17:0] triple(input logic [CH_W-1:0] x);
    return {2'b00, x} + {1'b0, x, 1'b0};
  endfunction

  // floor(6x / 10)
  function automatic logic [CH_W-1:0] tap_w6(input logic [CH_W-1:0] x);
    return div5(triple(x));
  endfunction

  // floor(3x / 10)
  function automatic logic [CH_W-1:0] tap_w3(input logic [CH_W-1:0] x);
    logic [17:0] y;
    y = triple(x);
    return div5({1'b0, y[17:1]});
  endfunction

  // floor(x / 10)
  function automatic logic [CH_W-1:0] tap_w1(input logic [CH_W-1:0] x);
    return div5({3'b000, x[CH_W-1:1]});
  endfunction

  // floor(3x / 100), as floor(floor(3x / 4) / 25)
  function automatic logic [CH_W-1:0] tap_w3h(input logic [CH_W-1:0] x);
    logic [17:0] y;
    logic [39:0] p;
    y = triple(x);
    p = 40'(y[17:2]) * 40'd83887;
    return p[36:21];
  endfunction

endpackage

>>> src/ws3_stream_if.sv
// ----------------------------------------------------------------------------
// ws3_stream_if
// Valid/ready channels for source pixel items and result items.
// ----------------------------------------------------------------------------
interface ws3_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;

  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface ws3_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic        frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

>>> src/weighted_stencil_3x3_rgb.sv
// ----------------------------------------------------------------------------
// weighted_stencil_3x3_rgb
// Forward 3x3 weighted stencil over a square RGB image in raster order.
// ----------------------------------------------------------------------------
// The block takes one item per clock and gives one result per clock once its
// pipeline is primed; both sides may stall at any time. The result for pixel
// (i,j) comes out when the item 2*dim+2 places after that pixel is accepted,
// so the tail of a frame is pushed out with 2*dim+2 flush items; items between
// the last pixel and the frame end give zero data. Each accepted item does one
// write and one read in each of two line buffers of MAX_SIZE words of 48 bits,
// which sets the one item per clock figure; the result for an emitting item
// passes from its accept through the queue, line buffers, tap window, tap and
// sum registers. Writing image_size abandons the frame in progress; the user
// must write it only while idle, as the block does not enforce this itself.
module weighted_stencil_3x3_rgb import ws3_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  ws3_in_if.sink           pixel,
  ws3_out_if.source        result
);

  localparam int AW = $clog2(MAX_SIZE);
  localparam int QW = AW + $bits(ws3_ctl_t) + PIX_W;

  logic             push;
  logic [AW-1:0]    push_addr;
  ws3_ctl_t         push_ctl;
  logic [PIX_W-1:0] push_pix;
  logic             full;
  logic             q_valid;
  logic [QW-1:0]    q_data;
  logic             q_pop;
  logic [AW-1:0]    q_addr;
  ws3_ctl_t         q_ctl;
  logic [PIX_W-1:0] q_pix;

  ws3_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pixel     (pixel),
    .push      (push),
    .push_addr (push_addr),
    .push_ctl  (push_ctl),
    .push_pix  (push_pix),
    .full      (full)
  );

  ws3_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_addr, push_ctl, push_pix}),
    .full      (full),
    .valid     (q_valid),
    .data      (q_data),
    .pop       (q_pop)
  );

  assign {q_addr, q_ctl, q_pix} = q_data;

  ws3_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_addr  (q_addr),
    .q_ctl   (q_ctl),
    .q_pix   (q_pix),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

>>> src/ws3_front.sv
// ----------------------------------------------------------------------------
// ws3_front
// Accepts items, tracks frame position, zeroes flush and surplus data and
// tags each item with line buffer column, emit flag, frame end and tap masks.
// ----------------------------------------------------------------------------
module ws3_front import ws3_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF,
  localparam int AW = $clog2(MAX_SIZE),
  localparam int DW = $clog2(MAX_SIZE + 1),
  localparam int EW = DW + 1,
  localparam int LW = DW + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  ws3_in_if.sink            pixel,
  output logic              push,
  output logic [AW-1:0]     push_addr,
  output ws3_ctl_t          push_ctl,
  output logic [PIX_W-1:0]  push_pix,
  input  logic              full
);

  logic [CFG_W-1:0] image_size;
  logic [DW-1:0]    dim;
  logic [LW-1:0]    lag;
  logic [AW-1:0]    in_col;
  logic [DW-1:0]    in_row;
  logic [LW-1:0]    lag_cnt;
  logic [AW-1:0]    oi;
  logic [AW-1:0]    oj;
  logic             accept;
  logic             idle_flush;
  logic             col_last;
  logic             pixels_done;
  logic             emit;
  logic             oi_last;
  logic             oj_last;
  logic [EW-1:0]    oi_p1;
  logic [EW-1:0]    oi_p2;
  logic [EW-1:0]    oj_p1;
  logic [EW-1:0]    oj_p2;

  always_comb begin
    if (image_size == '0) begin
      dim = DW'(1);
    end else if (32'(image_size) > MAX_SIZE) begin
      dim = DW'(MAX_SIZE);
    end else begin
      dim = DW'(image_size);
    end
  end

  assign lag = {1'b0, dim, 1'b0} + LW'(2);

  assign accept      = pixel.valid && pixel.ready;
  assign idle_flush  = (pixel.action == ACT_FLUSH) && (lag_cnt == '0);
  assign push        = accept && !idle_flush;
  assign pixel.ready = !full;

  assign col_last    = (EW'(in_col) + EW'(1)) == EW'(dim);
  assign pixels_done = in_row == dim;
  assign emit        = lag_cnt == lag;

  assign oi_p1   = EW'(oi) + EW'(1);
  assign oi_p2   = EW'(oi) + EW'(2);
  assign oj_p1   = EW'(oj) + EW'(1);
  assign oj_p2   = EW'(oj) + EW'(2);
  assign oi_last = oi_p1 == EW'(dim);
  assign oj_last = oj_p1 == EW'(dim);

  assign push_addr     = in_col;
  assign push_ctl.emit = emit;
  assign push_ctl.last = emit && oi_last && oj_last;
  assign push_ctl.row1 = oi_p1 < EW'(dim);
  assign push_ctl.row2 = oi_p2 < EW'(dim);
  assign push_ctl.col1 = oj_p1 < EW'(dim);
  assign push_ctl.col2 = oj_p2 < EW'(dim);

  always_comb begin
    if ((pixel.action == ACT_FLUSH) || pixels_done) begin
      push_pix = '0;
    end else begin
      push_pix = {pixel.blue_in, pixel.green_in, pixel.red_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SIZE_RESET;
      in_col     <= '0;
      in_row     <= '0;
      lag_cnt    <= '0;
      oi         <= '0;
      oj         <= '0;
    end else if (cfg_we) begin
      image_size <= cfg_wdata;
      in_col     <= '0;
      in_row     <= '0;
      lag_cnt    <= '0;
      oi         <= '0;
      oj         <= '0;
    end else if (push) begin
      if (push_ctl.last) begin
        in_col  <= '0;
        in_row  <= '0;
        lag_cnt <= '0;
        oi      <= '0;
        oj      <= '0;
      end else begin
        if (col_last) begin
          in_col <= '0;
          if (!pixels_done) begin
            in_row <= in_row + DW'(1);
          end
        end else begin
          in_col <= in_col + AW'(1);
        end
        if (!emit) begin
          lag_cnt <= lag_cnt + LW'(1);
        end else if (oj_last) begin
          oj <= '0;
          oi <= oi + AW'(1);
        end else begin
          oj <= oj + AW'(1);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) EW'(in_col) < EW'(dim))
    else $error("line buffer column beyond image width");

  assert property (@(posedge clk) disable iff (rst) in_row <= dim)
    else $error("input row count beyond image height");

  assert property (@(posedge clk) disable iff (rst)
    push && push_ctl.last && !cfg_we |=> lag_cnt == '0 && in_col == '0 && oi == '0)
    else $error("frame counters not cleared after frame end");

endmodule

>>> src/ws3_queue.sv
// ----------------------------------------------------------------------------
// ws3_queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module ws3_queue import ws3_pkg::*; #(
  parameter int W     = PIX_W,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = PW + 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] data,
  input  logic         pop
);

  logic [W-1:0]  entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign valid = count != '0;
  assign data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("item written into full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("item read from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CW'(1))
    else $error("queue fill count lost an item");

endmodule

>>> src/ws3_back.sv
// ----------------------------------------------------------------------------
// ws3_back
// Two line buffers, the 3x3 tap window, fixed-weight taps and the channel
// sums, ending in the result register.
// ----------------------------------------------------------------------------
module ws3_back import ws3_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF,
  localparam int AW = $clog2(MAX_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [AW-1:0]    q_addr,
  input  ws3_ctl_t         q_ctl,
  input  logic [PIX_W-1:0] q_pix,
  output logic             q_pop,
  ws3_out_if.source        result
);

  logic [PIX_W-1:0] line0 [MAX_SIZE];
  logic [PIX_W-1:0] line1 [MAX_SIZE];

  logic             adv;
  logic             s1_v;
  logic             s2_v;
  logic             s3_v;
  logic             s4_v;
  logic             out_v;

  logic [PIX_W-1:0] s1_pix;
  logic [PIX_W-1:0] s1_l1;
  logic [AW-1:0]    s1_addr;
  ws3_ctl_t         s1_ctl;
  logic [PIX_W-1:0] s2_pix;
  logic [PIX_W-1:0] s2_l1;
  logic [PIX_W-1:0] s2_l2;
  ws3_ctl_t         s2_ctl;
  ws3_ctl_t         s3_ctl;
  logic             s4_last;

  logic [PIX_W-1:0] w00;
  logic [PIX_W-1:0] w01;
  logic [PIX_W-1:0] w02;
  logic [PIX_W-1:0] w10;
  logic [PIX_W-1:0] w11;
  logic [PIX_W-1:0] w12;
  logic [PIX_W-1:0] w21;
  logic [PIX_W-1:0] w22;

  logic [CH_W-1:0]  tq_next [3][7];
  logic [CH_W-1:0]  tq      [3][7];
  logic [CH_W-1:0]  sum     [3];
  logic [CH_W-1:0]  out_ch  [3];
  logic             out_last;

  assign adv   = !out_v || result.ready;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      s1_v  <= q_valid;
      s2_v  <= s1_v;
      s3_v  <= s2_v && s2_ctl.emit;
      s4_v  <= s3_v;
      out_v <= s4_v;
    end
  end

  // first line buffer: item n in, item n - dim out
  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      line0[q_addr] <= q_pix;
      s1_l1         <= line0[q_addr];
    end
  end

  // second line buffer: item n - dim in, item n - 2*dim out
  always_ff @(posedge clk) begin
    if (adv && s1_v) begin
      line1[s1_addr] <= s1_l1;
      s2_l2          <= line1[s1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix  <= q_pix;
      s1_addr <= q_addr;
      s1_ctl  <= q_ctl;
      s2_pix  <= s1_pix;
      s2_l1   <= s1_l1;
      s2_ctl  <= s1_ctl;
      if (s2_v) begin
        w22 <= s2_pix;
        w21 <= w22;
        w12 <= s2_l1;
        w11 <= w12;
        w10 <= w11;
        w02 <= s2_l2;
        w01 <= w02;
        w00 <= w01;
      end
      s3_ctl  <= s2_ctl;
      tq      <= tq_next;
      s4_last <= s3_ctl.last;
      out_ch  <= sum;
      out_last <= s4_last;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tq_next[c][0] = tap_w6(w00[c*CH_W +: CH_W]);
      tq_next[c][1] = s3_ctl.col1 ? tap_w3h(w01[c*CH_W +: CH_W]) : '0;
      tq_next[c][2] = s3_ctl.row1 ? tap_w3h(w10[c*CH_W +: CH_W]) : '0;
      tq_next[c][3] = (s3_ctl.row1 && s3_ctl.col1) ? tap_w3(w11[c*CH_W +: CH_W]) : '0;
      tq_next[c][4] = (s3_ctl.row1 && s3_ctl.col2) ? tap_w3h(w12[c*CH_W +: CH_W]) : '0;
      tq_next[c][5] = (s3_ctl.row2 && s3_ctl.col1) ? tap_w3h(w21[c*CH_W +: CH_W]) : '0;
      tq_next[c][6] = (s3_ctl.row2 && s3_ctl.col2) ? tap_w1(w22[c*CH_W +: CH_W]) : '0;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = tq[c][0] + tq[c][1] + tq[c][2] + tq[c][3]
             + tq[c][4] + tq[c][5] + tq[c][6];
    end
  end

  assign result.valid      = out_v;
  assign result.red_out    = out_ch[0];
  assign result.green_out  = out_ch[1];
  assign result.blue_out   = out_ch[2];
  assign result.frame_last = out_last;

  assert property (@(posedge clk) disable iff (rst) s4_v && !adv |=> s4_v)
    else $error("tap stage dropped an item while stalled");

  assert property (@(posedge clk) disable iff (rst) s1_v && adv |=> s2_v)
    else $error("line buffer stage lost an item");

  assert property (@(posedge clk) disable iff (rst) $rose(out_v) |-> $past(s4_v))
    else $error("result shown without a summed item behind it");

endmodule
